>>> rtl/longest_window_sum_at_most_limit_macros.svh
// Assertion macros shared by the checker.
`ifndef LONGEST_WINDOW_SUM_AT_MOST_LIMIT_MACROS_SVH
`define LONGEST_WINDOW_SUM_AT_MOST_LIMIT_MACROS_SVH

// same-cycle implication, masked while in reset
`define LWSL_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked through reset
`define LWSL_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/lwsl_pkg.sv
`default_nettype none
package lwsl_pkg;

  localparam int VALUE_W        = 16;
  localparam int LEN_W          = 11;
  localparam int LIMIT_W        = 26;
  // window sum before shrinking is at most limit + one value
  localparam int SUM_W          = LIMIT_W + 1;
  localparam int MAX_ITEMS_DEF  = 1024;
  localparam int VALUE_BITS_DEF = 16;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] best_len;
    logic [LEN_W-1:0] window_len;
    logic             done_res;
    logic             overflow;
  } out_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               ovf;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHECK,
    BK_POP
  } back_state_t;

endpackage
`default_nettype wire

>>> rtl/longest_window_sum_at_most_limit.sv
// channel | signals                          | handshake
// --------+----------------------------------+------------------
// cfg     | cfg_we, cfg_wdata (sum_limit)    | write, no wait
// in      | in_valid, in_ready, in_item      | beat on valid&ready
// out     | out_valid, out_ready, out_item   | beat on valid&ready
//
// Item path in the back end: an overflowed item is reported from idle; any
// other item is written in idle, then checked, and each of the d oldest
// values dropped is popped before the check repeats. The window RAM has one read port with registered data.
// Reset is synchronous; the window RAM is not cleared and needs no sweep.
// A 2-entry queue keeps in_ready high until two beats wait behind a busy
// back end or a result stalled in the output register.
`default_nettype none
module longest_window_sum_at_most_limit #(
  parameter int MAX_ITEMS  = lwsl_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = lwsl_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [lwsl_pkg::LIMIT_W-1:0] cfg_wdata,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire lwsl_pkg::in_item_t           in_item,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      lwsl_pkg::out_item_t          out_item
);

  import lwsl_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic               q_full;
  logic               q_push;
  q_item_t            q_item;
  q_head_t            q_head;
  logic               q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  lwsl_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  lwsl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .head      (q_head),
    .pop       (q_pop)
  );

  lwsl_back #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit_r),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

>>> rtl/lwsl_ram.sv
`default_nettype none
module lwsl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

>>> rtl/lwsl_queue.sv
`default_nettype none
module lwsl_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire lwsl_pkg::q_item_t push_item,
  output      logic              full,
  output      lwsl_pkg::q_head_t head,
  input  wire logic              pop
);

  import lwsl_pkg::*;

  q_item_t    ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lwsl_front.sv
`default_nettype none
module lwsl_front #(
  parameter int MAX_ITEMS = lwsl_pkg::MAX_ITEMS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire lwsl_pkg::in_item_t in_item,
  input  wire logic               q_full,
  output      logic               q_push,
  output      lwsl_pkg::q_item_t  q_item
);

  import lwsl_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic             ovf;

  assign in_ready     = !q_full;
  assign q_push       = in_valid && in_ready;
  assign ovf          = (seen_r == CNT_W'(MAX_ITEMS));
  assign q_item.value = in_item.value;
  assign q_item.last  = in_item.last;
  assign q_item.ovf   = ovf;

  always_comb begin
    seen_nxt = seen_r;
    if (q_push) begin
      if (in_item.last) begin
        seen_nxt = '0;
      end else if (!ovf) begin
        seen_nxt = seen_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lwsl_back.sv
`default_nettype none
module lwsl_back #(
  parameter int MAX_ITEMS  = lwsl_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = lwsl_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [lwsl_pkg::LIMIT_W-1:0] limit,
  input  wire lwsl_pkg::q_head_t            q_head,
  output      logic                         q_pop,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      lwsl_pkg::out_item_t          out_item
);

  import lwsl_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int PTR_W = $clog2(MAX_ITEMS);
  localparam int VB_W  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

  back_state_t      state_r, state_nxt;
  logic [PTR_W-1:0] oldest_r, oldest_nxt;
  logic [PTR_W-1:0] newest_r, newest_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0] best_f;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] sum_sub;
  logic [SUM_W-1:0] limit_x;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic             out_free;

  logic             ram_we;
  logic [PTR_W-1:0] ram_raddr;
  logic [VB_W-1:0]  ram_rdata;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_ITEMS - 1)) ? '0 : p + 1'b1;
  endfunction

  lwsl_ram #(
    .WIDTH (VB_W),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (newest_r),
    .wr_data (q_head.item.value[VB_W-1:0]),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || out_ready;
  assign limit_x   = {1'b0, limit};
  assign sum_sub   = sum_r - SUM_W'(ram_rdata);
  assign best_f    = (count_r > best_r) ? count_r : best_r;

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    newest_nxt    = newest_r;
    count_nxt     = count_r;
    best_nxt      = best_r;
    sum_nxt       = sum_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = oldest_r;

    unique case (state_r)
      BK_IDLE: begin
        if (q_head.valid) begin
          if (q_head.item.ovf) begin
            // sequence full: report current state, window untouched unless the item is last
            if (out_free) begin
              q_pop                    = 1'b1;
              out_valid_nxt            = 1'b1;
              out_item_nxt.best_len    = LEN_W'(best_r);
              out_item_nxt.window_len  = LEN_W'(count_r);
              out_item_nxt.done_res    = q_head.item.last;
              out_item_nxt.overflow    = 1'b1;
              if (q_head.item.last) begin
                oldest_nxt = '0;
                newest_nxt = '0;
                count_nxt  = '0;
                best_nxt   = '0;
                sum_nxt    = '0;
              end
            end
          end else begin
            q_pop      = 1'b1;
            ram_we     = 1'b1;
            newest_nxt = ptr_inc(newest_r);
            count_nxt  = count_r + 1'b1;
            sum_nxt    = sum_r + SUM_W'(q_head.item.value[VB_W-1:0]);
            last_nxt   = q_head.item.last;
            state_nxt  = BK_CHECK;
          end
        end
      end
      BK_CHECK: begin
        // nonzero sum implies a nonempty window, so no count test needed
        if (sum_r > limit_x) begin
          state_nxt = BK_POP;
        end else if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.best_len   = LEN_W'(best_f);
          out_item_nxt.window_len = LEN_W'(count_r);
          out_item_nxt.done_res   = last_r;
          out_item_nxt.overflow   = 1'b0;
          best_nxt                = best_f;
          if (last_r) begin
            oldest_nxt = '0;
            newest_nxt = '0;
            count_nxt  = '0;
            best_nxt   = '0;
            sum_nxt    = '0;
          end
          state_nxt = BK_IDLE;
        end
      end
      BK_POP: begin
        // rdata holds the oldest entry; prefetch the one behind it
        oldest_nxt = ptr_inc(oldest_r);
        ram_raddr  = ptr_inc(oldest_r);
        count_nxt  = count_r - 1'b1;
        sum_nxt    = sum_sub;
        if (!(sum_sub > limit_x)) begin
          state_nxt = BK_CHECK;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      oldest_r    <= '0;
      newest_r    <= '0;
      count_r     <= '0;
      best_r      <= '0;
      sum_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      newest_r    <= newest_nxt;
      count_r     <= count_nxt;
      best_r      <= best_nxt;
      sum_r       <= sum_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/lwsl_checker.sv
`default_nettype none
`include "longest_window_sum_at_most_limit_macros.svh"
module lwsl_checker #(
  parameter int MAX_ITEMS = lwsl_pkg::MAX_ITEMS_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire lwsl_pkg::out_item_t          out_item
);

  import lwsl_pkg::*;

  logic wide_len;
  logic stalled;
  logic ovf_beat;
  logic len_ok;
  logic cap_ok;

  assign wide_len = (MAX_ITEMS > 2047);
  assign stalled  = rst_n && out_valid && !out_ready;
  assign ovf_beat = out_valid && out_item.overflow;
  assign len_ok   = wide_len || (out_item.best_len >= out_item.window_len);
  assign cap_ok   = wide_len || (out_item.best_len <= LEN_W'(MAX_ITEMS));

  `LWSL_ASSERT_NEXT(a_out_hold, clk, stalled, out_valid && $stable(out_item), "stalled beat changed")

  `LWSL_ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_valid, "result valid right after reset")

  `LWSL_ASSERT(a_best_ge_window, clk, rst_n, out_valid, len_ok, "best below window length")

  `LWSL_ASSERT(a_ovf_len_bound, clk, rst_n, ovf_beat, cap_ok, "best length beyond capacity")

endmodule

bind longest_window_sum_at_most_limit lwsl_checker #(.MAX_ITEMS(MAX_ITEMS)) u_lwsl_checker (.*);
`default_nettype wire
